@@ sv/chipset_index_regs_shadow_decode_top_assert.svh @@
// Assertion macros for the chipset config port block.
`ifndef CHIPSET_INDEX_REGS_SHADOW_DECODE_TOP_ASSERT_SVH
`define CHIPSET_INDEX_REGS_SHADOW_DECODE_TOP_ASSERT_SVH
`ifndef SYNTH
`define CISD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cisd assertion failed");
`define CISD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cisd assertion failed");
`else
`define CISD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CISD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/cisd_pkg.sv @@
`default_nettype none
package cisd_pkg;
    localparam int REG_COUNT = 18;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [1:0] MODE_IO_WR    = 2'd0;
    localparam logic [1:0] MODE_IO_RD    = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;

    localparam logic [15:0] PORT_INDEX = 16'h0022;
    localparam logic [15:0] PORT_DATA  = 16'h0024;
    localparam logic [19:0] SHADOW_BASE = 20'hc0000;

    localparam logic [7:0] IDX_CTRL0    = 8'h00;
    localparam logic [7:0] IDX_CACHE    = 8'h02;
    localparam logic [7:0] IDX_SHADOW_C = 8'h04;
    localparam logic [7:0] IDX_SHADOW_D = 8'h05;
    localparam logic [7:0] IDX_SHADOW_EF = 8'h06;
    localparam logic [7:0] IDX_MASKED_C = 8'h0c;

    localparam logic [7:0] MASK_CTRL0    = 8'h7f;
    localparam logic [7:0] MASK_REG_C    = 8'hcf;
    localparam logic [7:0] CACHE_EN_MASK = 8'h0c;
    localparam logic [7:0] READ_IDLE     = 8'hff;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WR_INDEX,
        OP_WR_DATA,
        OP_RD_DATA,
        OP_CLASSIFY
    } t_op;

    typedef enum logic [1:0] {
        SEL_C,
        SEL_D,
        SEL_EF
    } t_rsel;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        t_rsel      rsel;
        logic [2:0] bitpos;
    } t_cmd;
endpackage
`default_nettype wire

@@ sv/chipset_index_regs_shadow_decode_top.sv @@
// Chipset index/data configuration port with shadow-RAM routing decode.
// Input channel (i_valid/o_ready) carries one bus request: an I/O write,
// an I/O read, or a memory address to classify. Port 0x22 latches the
// index, port 0x24 reads or writes the indexed byte of an 18-entry file.
// Output channel (o_valid/i_ready) returns exactly one result per request:
// read data, shadow range hit, DRAM versus AT bus routing, cache enable.
// A request passes through the front register, then the queue, then the
// back end output register.
// Throughput: one request per cycle while the receiver does not stall; the
// back end executes one queue entry per cycle, when its output register is free,
// against the register file, which is the serial point. A two-entry queue
// separates the classifier from the executor, so the front keeps taking
// requests while the receiver stalls, until the front register and the queue are full; then o_ready drops.
// Reset (i_rst_n low, synchronous) clears the index, the whole register
// file and all valid state; no requests are pending after reset.
`default_nettype none
`include "chipset_index_regs_shadow_decode_top_assert.svh"
module chipset_index_regs_shadow_decode_top import cisd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_io_port,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [19:0] i_mem_address,
    input  wire logic        i_mem_is_write,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_read_data,
    output logic             o_in_shadow_range,
    output logic             o_route_to_dram,
    output logic             o_ext_cache_enabled
);
    // front to queue
    logic   front_valid;
    t_cmd   front_cmd;
    logic   q_full;
    logic   q_push;
    // queue to back end
    logic   q_head_valid;
    t_cmd   q_head_cmd;
    logic   q_pop;
    logic [QAW:0] q_count;

    // advance the front register only when the queue has room
    assign q_push = front_valid && !q_full;

    cisd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_io_port      (i_io_port),
        .i_write_data   (i_write_data),
        .i_mem_address  (i_mem_address),
        .i_mem_is_write (i_mem_is_write),
        .o_cmd_valid    (front_valid),
        .i_cmd_ready    (!q_full),
        .o_cmd          (front_cmd)
    );

    cisd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_cmd   (front_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head_cmd   (q_head_cmd),
        .o_count      (q_count)
    );

    // execute in order; hold the result while the receiver stalls
    cisd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head_valid        (q_head_valid),
        .i_head_cmd          (q_head_cmd),
        .o_pop               (q_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_read_data         (o_read_data),
        .o_in_shadow_range   (o_in_shadow_range),
        .o_route_to_dram     (o_route_to_dram),
        .o_ext_cache_enabled (o_ext_cache_enabled)
    );

    `CISD_ASSERT_IMPL(a_route_needs_range, i_clk, i_rst_n, o_valid && o_route_to_dram, o_in_shadow_range)
    `CISD_ASSERT_IMPL(a_classify_no_read, i_clk, i_rst_n, o_valid && o_in_shadow_range, o_read_data == READ_IDLE)
    `CISD_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, q_count <= (QAW+1)'(QDEPTH))
    `CISD_ASSERT_NEXT(a_full_blocks_push, i_clk, i_rst_n, q_full && !q_pop, q_full)
endmodule
`default_nettype wire

@@ sv/cisd_front.sv @@
`default_nettype none
module cisd_front import cisd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_io_port,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [19:0] i_mem_address,
    input  wire logic        i_mem_is_write,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);
    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // classify the request into one operation for the back end
    always_comb begin
        n_cmd        = '0;
        n_cmd.op     = OP_NONE;
        n_cmd.rsel   = SEL_C;
        n_cmd.data   = i_write_data;
        n_cmd.bitpos = {i_mem_address[15:14], i_mem_is_write};
        unique case (i_mode)
            MODE_IO_WR: begin
                if (i_io_port == PORT_INDEX) begin
                    n_cmd.op = OP_WR_INDEX;
                end else if (i_io_port == PORT_DATA) begin
                    n_cmd.op = OP_WR_DATA;
                end
            end
            MODE_IO_RD: begin
                if (i_io_port == PORT_DATA) begin
                    n_cmd.op = OP_RD_DATA;
                end
            end
            MODE_CLASSIFY: begin
                if (i_mem_address >= SHADOW_BASE) begin
                    n_cmd.op = OP_CLASSIFY;
                    case (i_mem_address[17:16])
                        2'b00:   n_cmd.rsel = SEL_C;
                        2'b01:   n_cmd.rsel = SEL_D;
                        default: begin
                            n_cmd.rsel   = SEL_EF;
                            n_cmd.bitpos = {1'b0, i_mem_address[16], i_mem_is_write};
                        end
                    endcase
                end
            end
            default: n_cmd.op = OP_NONE;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end
endmodule
`default_nettype wire

@@ sv/cisd_queue.sv @@
`default_nettype none
module cisd_queue import cisd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_head_valid,
    output t_cmd      o_head_cmd,
    output logic [QAW:0] o_count
);
    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_full       = (r_count == (QAW+1)'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_mem[r_rptr];
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end
endmodule
`default_nettype wire

@@ sv/cisd_back.sv @@
`default_nettype none
module cisd_back import cisd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_head_valid,
    input  wire t_cmd i_head_cmd,
    output logic      o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_read_data,
    output logic       o_in_shadow_range,
    output logic       o_route_to_dram,
    output logic       o_ext_cache_enabled
);
    logic [7:0] r_index;
    logic [7:0] r_regs [REG_COUNT];
    logic       r_valid;
    logic [7:0] r_read_data;
    logic       r_in_range;
    logic       r_dram;
    logic       r_cache;

    logic [7:0]        n_index;
    logic [7:0]        n_read_data;
    logic              n_in_range;
    logic              n_dram;
    logic              n_cache;
    logic              index_ok;
    logic [REG_AW-1:0] ridx;
    logic [7:0]        wr_val;
    logic [7:0]        shadow_reg;
    logic [7:0]        cache_reg;
    logic              reg_we;

    assign index_ok = (r_index < 8'(REG_COUNT));
    assign ridx     = r_index[REG_AW-1:0];
    assign o_pop    = i_head_valid && (!r_valid || i_ready);
    assign reg_we   = o_pop && (i_head_cmd.op == OP_WR_DATA) && index_ok;

    always_comb begin
        n_index     = r_index;
        n_read_data = READ_IDLE;
        n_in_range  = 1'b0;
        n_dram      = 1'b0;

        // two registers keep some bits tied low
        if (r_index == IDX_CTRL0) begin
            wr_val = i_head_cmd.data & MASK_CTRL0;
        end else if (r_index == IDX_MASKED_C) begin
            wr_val = i_head_cmd.data & MASK_REG_C;
        end else begin
            wr_val = i_head_cmd.data;
        end

        case (i_head_cmd.rsel)
            SEL_C:   shadow_reg = r_regs[REG_AW'(IDX_SHADOW_C)];
            SEL_D:   shadow_reg = r_regs[REG_AW'(IDX_SHADOW_D)];
            default: shadow_reg = r_regs[REG_AW'(IDX_SHADOW_EF)];
        endcase

        unique case (i_head_cmd.op)
            OP_WR_INDEX: n_index = i_head_cmd.data;
            OP_RD_DATA: begin
                if (index_ok) begin
                    n_read_data = r_regs[ridx];
                end
            end
            OP_CLASSIFY: begin
                n_in_range = 1'b1;
                n_dram     = shadow_reg[i_head_cmd.bitpos];
            end
            default: ;
        endcase

        // cache enable sees this request's own write
        cache_reg = (reg_we && r_index == IDX_CACHE) ? wr_val
                                                     : r_regs[REG_AW'(IDX_CACHE)];
        n_cache   = |(cache_reg & CACHE_EN_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_index <= n_index;
            end
            if (reg_we) begin
                r_regs[ridx] <= wr_val;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_read_data <= n_read_data;
            r_in_range  <= n_in_range;
            r_dram      <= n_dram;
            r_cache     <= n_cache;
        end
    end

    assign o_valid             = r_valid;
    assign o_read_data         = r_read_data;
    assign o_in_shadow_range   = r_in_range;
    assign o_route_to_dram     = r_dram;
    assign o_ext_cache_enabled = r_cache;
endmodule
`default_nettype wire

@@ tb/chipset_index_regs_shadow_decode_top_test.sv @@
module chipset_index_regs_shadow_decode_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cisd_pkg::*;

    // Mode 3 has no name in the package; the block must treat it as a no-op.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Upper address nibble of the shadowed segments.
    localparam logic [3:0] SEG_C = 4'hc;
    localparam logic [3:0] SEG_D = 4'hd;
    localparam logic [3:0] SEG_E = 4'he;

    localparam int IDLE_PCT        = 11;
    localparam int RANDOM_REQUESTS = 1925;
    localparam int HOLD_AT         = 600;     // random request that starts the long hold-off
    localparam int HOLD_CYCLES     = 300;
    localparam int CALM_FROM       = 1200;    // stretch with no idling on either side
    localparam int CALM_TO         = 1500;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DIRECTED_ROWS   = 25;

    localparam bit PIN  = 1'b1;   // expected result typed into the row
    localparam bit CALC = 1'b0;   // expected result comes from the decoder model

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] port;
        logic [7:0]  data;
        logic [19:0] addr;
        logic        is_wr;
    } bus_req_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       in_range;
        logic       dram;
        logic       cache;
    } bus_result_t;

    typedef struct packed {
        bus_req_t    req;
        logic        pinned;
        bus_result_t res;
    } bus_row_t;

    localparam bus_result_t NO_HIT      = '{READ_IDLE, 1'b0, 1'b0, 1'b0};
    localparam bus_result_t NO_HIT_CACHE = '{READ_IDLE, 1'b0, 1'b0, 1'b1};

    // Indexes worth hitting often: cache control and the three shadow controls.
    localparam logic [7:0] HOT_IDX [4] = '{IDX_CACHE, IDX_SHADOW_C, IDX_SHADOW_D,
                                            IDX_SHADOW_EF};

    // Directed walk: reset values, masking, out-of-range index, stray ports,
    // the unused mode, the range edges and the cache enable turning on.
    bus_row_t script [DIRECTED_ROWS] = '{
        // read register 0 straight out of reset
        '{'{MODE_IO_RD, PORT_DATA, 8'h00, 20'h00000, 1'b0}, PIN,
          '{8'h00, 1'b0, 1'b0, 1'b0}},
        // read of a port that is neither index nor data
        '{'{MODE_IO_RD, 16'h0000, 8'h00, 20'h00000, 1'b0}, PIN, NO_HIT},
        // top of memory, all shadow bits clear: AT bus
        '{'{MODE_CLASSIFY, 16'hffff, 8'hff, 20'hfffff, 1'b1}, PIN,
          '{READ_IDLE, 1'b1, 1'b0, 1'b0}},
        // bottom of memory: outside the shadow range
        '{'{MODE_CLASSIFY, 16'h0000, 8'h00, 20'h00000, 1'b0}, PIN, NO_HIT},
        // register 0 keeps only its low seven bits
        '{'{MODE_IO_WR, PORT_DATA, 8'hff, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_RD, PORT_DATA, 8'h00, 20'h00000, 1'b0}, PIN,
          '{8'h7f, 1'b0, 1'b0, 1'b0}},
        // register 0x0c drops bits 4 and 5
        '{'{MODE_IO_WR, PORT_INDEX, IDX_MASKED_C, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_WR, PORT_DATA, 8'hff, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_RD, PORT_DATA, 8'h00, 20'h00000, 1'b0}, PIN,
          '{8'hcf, 1'b0, 1'b0, 1'b0}},
        // first index past the file: write dropped, read idle
        '{'{MODE_IO_WR, PORT_INDEX, 8'h12, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_WR, PORT_DATA, 8'h55, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_RD, PORT_DATA, 8'h00, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_WR, PORT_INDEX, 8'hff, 20'h00000, 1'b0}, PIN, NO_HIT},
        '{'{MODE_IO_RD, PORT_DATA, 8'h00, 20'h00000, 1'b0}, PIN, NO_HIT},
        // write to a stray port is dropped
        '{'{MODE_IO_WR, 16'hffff, 8'haa, 20'hfffff, 1'b1}, PIN, NO_HIT},
        // unused mode with every field loaded
        '{'{MODE_UNUSED, PORT_DATA, 8'hff, 20'hfffff, 1'b1}, PIN, NO_HIT},
        // turn the external cache on, then program segment C
        '{'{MODE_IO_WR, PORT_INDEX, IDX_CACHE, 20'h00000, 1'b0}, CALC, NO_HIT},
        '{'{MODE_IO_WR, PORT_DATA, 8'hff, 20'h00000, 1'b0}, CALC, NO_HIT},
        '{'{MODE_IO_WR, PORT_INDEX, IDX_SHADOW_C, 20'h00000, 1'b0}, CALC, NO_HIT},
        '{'{MODE_IO_WR, PORT_DATA, 8'h5a, 20'h00000, 1'b0}, CALC, NO_HIT},
        '{'{MODE_CLASSIFY, 16'h0000, 8'h00, 20'hc4000, 1'b0}, CALC, NO_HIT},
        // last address below the shadow range
        '{'{MODE_CLASSIFY, 16'h0000, 8'h00, 20'hbffff, 1'b1}, PIN, NO_HIT_CACHE},
        // reading the index port gives the idle byte
        '{'{MODE_IO_RD, PORT_INDEX, 8'h00, 20'h00000, 1'b0}, PIN, NO_HIT_CACHE},
        // last valid index
        '{'{MODE_IO_WR, PORT_INDEX, 8'h11, 20'h00000, 1'b0}, CALC, NO_HIT},
        '{'{MODE_IO_WR, PORT_DATA, 8'h00, 20'h00000, 1'b0}, CALC, NO_HIT}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_mode         = 2'd0;
    logic [15:0] i_io_port      = 16'h0000;
    logic [7:0]  i_write_data   = 8'h00;
    logic [19:0] i_mem_address  = 20'h00000;
    logic        i_mem_is_write = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic        o_in_shadow_range;
    logic        o_route_to_dram;
    logic        o_ext_cache_enabled;

    // Decoder model state: the latched index and the register file.
    logic [7:0]  index_latch = 8'h00;
    logic [7:0]  config_bytes [REG_COUNT] = '{default: 8'h00};

    bus_row_t    pin_q [$];        // one entry per request offered, in order
    bus_result_t result_q [$];     // results owed by the block, oldest first
    int          errors      = 0;
    int          cycle_count = 0;
    bit          calm         = 1'b0;
    bit          hold_off_req = 1'b0;

    chipset_index_regs_shadow_decode_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_io_port           (i_io_port),
        .i_write_data        (i_write_data),
        .i_mem_address       (i_mem_address),
        .i_mem_is_write      (i_mem_is_write),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_read_data         (o_read_data),
        .o_in_shadow_range   (o_in_shadow_range),
        .o_route_to_dram     (o_route_to_dram),
        .o_ext_cache_enabled (o_ext_cache_enabled)
    );

    always #2 i_clk = ~i_clk;

    // Apply one request to the model state and return what the block owes.
    function automatic bus_result_t decode_request(bus_req_t r);
        bus_result_t res;
        logic [7:0]  v;
        logic [7:0]  ctl;
        logic [3:0]  seg;
        int          sel;
        res = NO_HIT;
        case (r.mode)
            MODE_IO_WR: begin
                if (r.port == PORT_INDEX) begin
                    index_latch = r.data;
                end else if (r.port == PORT_DATA && index_latch < REG_COUNT) begin
                    v = r.data;
                    if (index_latch == IDX_CTRL0) begin
                        v = v & MASK_CTRL0;
                    end else if (index_latch == IDX_MASKED_C) begin
                        v = v & MASK_REG_C;
                    end
                    config_bytes[index_latch] = v;
                end
            end
            MODE_IO_RD: begin
                if (r.port == PORT_DATA && index_latch < REG_COUNT) begin
                    res.rd = config_bytes[index_latch];
                end
            end
            MODE_CLASSIFY: begin
                if (r.addr >= SHADOW_BASE) begin
                    res.in_range = 1'b1;
                    seg = r.addr[19:16];
                    if (seg == SEG_C || seg == SEG_D) begin
                        // 16 KB granule: read bit 2g, write bit 2g+1
                        ctl = (seg == SEG_C) ? config_bytes[IDX_SHADOW_C]
                                             : config_bytes[IDX_SHADOW_D];
                        sel = 2 * int'(r.addr[15:14]) + int'(r.is_wr);
                    end else begin
                        ctl = config_bytes[IDX_SHADOW_EF];
                        sel = ((seg == SEG_E) ? 0 : 2) + int'(r.is_wr);
                    end
                    res.dram = ctl[sel];
                end
            end
            default: begin
            end
        endcase
        res.cache = |(config_bytes[IDX_CACHE] & CACHE_EN_MASK);
        return res;
    endfunction

    // Mostly index/data port traffic on the live registers, with stray ports,
    // stray indexes and the unused mode mixed in; addresses lean to the
    // shadow range but still cover the full 20 bits.
    function automatic bus_req_t random_request();
        bus_req_t r;
        int       pick;
        r.port  = 16'($urandom);
        r.data  = 8'($urandom);
        r.addr  = 20'($urandom);
        r.is_wr = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.mode = MODE_IO_WR;
        end else if (pick < 65) begin
            r.mode = MODE_IO_RD;
        end else if (pick < 95) begin
            r.mode = MODE_CLASSIFY;
        end else begin
            r.mode = MODE_UNUSED;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r.port = PORT_INDEX;
        end else if (pick < 85) begin
            r.port = PORT_DATA;
        end
        if (r.mode == MODE_IO_WR && r.port == PORT_INDEX) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r.data = HOT_IDX[$urandom_range(0, 3)];
            end else if (pick < 90) begin
                r.data = 8'($urandom_range(0, REG_COUNT - 1));
            end
        end
        if ($urandom_range(0, 99) < 75) begin
            r.addr[19:18] = 2'b11;
        end
        return r;
    endfunction

    // Offer one request and hold it until the block takes it. The only
    // assignment to i_valid in the step after acceptance happens here, so a
    // back-to-back request never sees valid dropped and raised in one step.
    task automatic offer(bus_row_t row);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pin_q.push_back(row);
        i_valid        <= 1'b1;
        i_mode         <= row.req.mode;
        i_io_port      <= row.req.port;
        i_write_data   <= row.req.data;
        i_mem_address  <= row.req.addr;
        i_mem_is_write <= row.req.is_wr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Accept side and result side share one block so that a request and a
    // result in the same cycle are handled in a fixed order.
    always @(posedge i_clk) begin
        bus_row_t    row;
        bus_result_t want;
        if (i_rst_n && i_valid && o_ready) begin
            row  = pin_q.pop_front();
            want = decode_request('{i_mode, i_io_port, i_write_data, i_mem_address,
                                    i_mem_is_write});
            if (row.pinned) begin
                want = row.res;
            end
            result_q.push_back(want);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = result_q.pop_front();
                if (o_read_data !== want.rd) begin
                    $error("read_data: expected %02h, got %02h", want.rd, o_read_data);
                    errors++;
                end
                if (o_in_shadow_range !== want.in_range) begin
                    $error("in_shadow_range: expected %0b, got %0b", want.in_range,
                           o_in_shadow_range);
                    errors++;
                end
                if (o_route_to_dram !== want.dram) begin
                    $error("route_to_dram: expected %0b, got %0b", want.dram,
                           o_route_to_dram);
                    errors++;
                end
                if (o_ext_cache_enabled !== want.cache) begin
                    $error("ext_cache_enabled: expected %0b, got %0b", want.cache,
                           o_ext_cache_enabled);
                    errors++;
                end
            end
        end
    end

    // Receiver: random back-pressure, a calm stretch, and one long hold-off
    // counted here while the sender keeps offering.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: give up if the run never drains.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            offer(script[k]);
        end

        // Random traffic; the model supplies every expectation.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            bus_row_t row;
            row.req    = random_request();
            row.pinned = CALC;
            row.res    = NO_HIT;
            if (n == HOLD_AT) begin
                hold_off_req = 1'b1;
            end
            calm = (n >= CALM_FROM && n < CALM_TO);
            offer(row);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // Drain, then give the pipeline time to show any stray result.
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d results never returned", result_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
